FILE: rtl/core/ukcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukcd_pkg
// Types, character codes and the keyword table of the keyword command decoder.
// ----------------------------------------------------------------------------
package ukcd_pkg;

	localparam int KeptLetters  = 10;
	localparam int KeywordCount = 27;

	localparam logic [7:0] CharBang = 8'h21;
	localparam logic [7:0] CharCr   = 8'h0d;
	localparam logic [7:0] CharLf   = 8'h0a;
	localparam logic [7:0] CharDel  = 8'h7f;
	localparam logic [7:0] CharBs   = 8'h08;
	localparam logic [7:0] CharA    = 8'h61;
	localparam logic [7:0] CharZ    = 8'h7a;

	typedef enum logic [1:0] {
		RegSplitCentral   = 2'd0,
		RegTransportGroup = 2'd1,
		RegHogpGroup      = 2'd2
	} reg_index_t;

	typedef enum logic [4:0] {
		CodeUnknown    = 5'd0,
		CodeReboot     = 5'd1,
		CodeBootPeriph = 5'd2,
		CodeBootloader = 5'd3,
		CodeNuke       = 5'd4,
		CodeBle        = 5'd5,
		CodeUsb        = 5'd6,
		CodeForget     = 5'd7,
		CodeProfiles   = 5'd8,
		CodePair       = 5'd9,
		CodeUnpair     = 5'd10,
		CodeScan       = 5'd11,
		CodeStatus     = 5'd12,
		CodeClearHosts = 5'd13,
		CodeClear      = 5'd14,
		CodeNvsClear   = 5'd15,
		CodeNvs        = 5'd16,
		CodeDebug      = 5'd17,
		CodeNoDebug    = 5'd18,
		CodeVersion    = 5'd19,
		CodeHelp       = 5'd20
	} cmd_code_t;

	typedef enum logic [1:0] {
		GroupAlways    = 2'd0,
		GroupSplit     = 2'd1,
		GroupTransport = 2'd2,
		GroupHogp      = 2'd3
	} group_t;

	typedef struct packed {
		logic split_central;
		logic transport_group;
		logic hogp_group;
	} cfg_t;

	typedef struct packed {
		logic      produce;
		cmd_code_t code;
		logic      debug;
	} line_result_t;

	typedef logic [KeptLetters-1:0][4:0] letters_t;

	typedef struct packed {
		logic [8*KeptLetters-1:0] word;
		logic [3:0]               len;
		cmd_code_t                code;
		group_t                   group;
	} keyword_t;

	localparam keyword_t Keywords [KeywordCount] = '{
		'{"reboot",     4'd6,  CodeReboot,     GroupAlways},
		'{"reset",      4'd5,  CodeReboot,     GroupAlways},
		'{"bootright",  4'd9,  CodeBootPeriph, GroupSplit},
		'{"bootperiph", 4'd10, CodeBootPeriph, GroupSplit},
		'{"boot",       4'd4,  CodeBootloader, GroupAlways},
		'{"flash",      4'd5,  CodeBootloader, GroupAlways},
		'{"dfu",        4'd3,  CodeBootloader, GroupAlways},
		'{"nuke",       4'd4,  CodeNuke,       GroupAlways},
		'{"ble",        4'd3,  CodeBle,        GroupTransport},
		'{"usb",        4'd3,  CodeUsb,        GroupTransport},
		'{"forget",     4'd6,  CodeForget,     GroupTransport},
		'{"profiles",   4'd8,  CodeProfiles,   GroupTransport},
		'{"prof",       4'd4,  CodeProfiles,   GroupTransport},
		'{"pair",       4'd4,  CodePair,       GroupHogp},
		'{"unpair",     4'd6,  CodeUnpair,     GroupHogp},
		'{"scan",       4'd4,  CodeScan,       GroupHogp},
		'{"hogp",       4'd4,  CodeStatus,     GroupHogp},
		'{"status",     4'd6,  CodeStatus,     GroupHogp},
		'{"clearhosts", 4'd10, CodeClearHosts, GroupHogp},
		'{"clear",      4'd5,  CodeClear,      GroupHogp},
		'{"nvsclear",   4'd8,  CodeNvsClear,   GroupHogp},
		'{"nvs",        4'd3,  CodeNvs,        GroupHogp},
		'{"debug",      4'd5,  CodeDebug,      GroupAlways},
		'{"nodebug",    4'd7,  CodeNoDebug,    GroupAlways},
		'{"version",    4'd7,  CodeVersion,    GroupAlways},
		'{"ver",        4'd3,  CodeVersion,    GroupAlways},
		'{"help",       4'd4,  CodeHelp,       GroupAlways}
	};

	// Letters are kept as the low five bits of their code, 1 for a through 26 for z.
	function automatic logic [4:0] kw_letter(input keyword_t kw, input int pos);
		int shift;
		shift = int'(kw.len) - 1 - pos;
		if (shift >= 0) begin
			return kw.word[8*shift +: 5];
		end
		return 5'd0;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/uart_keyword_command_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_keyword_command_decoder_top
// Turns received serial bytes into command codes by keyword prefix match.
// ----------------------------------------------------------------------------
// One received byte is taken per word on the input channel, one per cycle.
// Each byte is registered, then decoded against the line state in the next
// cycle; a line end that closes a non-empty command places one word with the
// command code and the debug flag in the output register when the registered
// byte is decoded. The keyword compare and the line state update form one
// loop, so bytes may follow back to back; the input stalls only when a
// result is due while the output register still holds an untaken word.
// ----------------------------------------------------------------------------
module uart_keyword_command_decoder_top #(
	parameter int BUFFER_LENGTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_enable,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] command_code,
	output logic       debug_enabled
);
	import ukcd_pkg::*;

	cfg_t         cfg_q;
	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         out_valid_q;
	cmd_code_t    code_q;
	logic         debug_q;
	line_result_t res;
	logic         out_free;
	logic         s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.split_central   <= 1'b0;
			cfg_q.transport_group <= 1'b1;
			cfg_q.hogp_group      <= 1'b1;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				RegSplitCentral:   cfg_q.split_central   <= cfg_data;
				RegTransportGroup: cfg_q.transport_group <= cfg_data;
				RegHogpGroup:      cfg_q.hogp_group      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ukcd_line_state #(
		.BUFFER_LENGTH(BUFFER_LENGTH)
	) u_line_state (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_go),
		.rx_byte(rx_byte_s1),
		.cfg    (cfg_q),
		.result (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && (!res.produce || out_free);
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s1_go && res.produce) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
		if (s1_go && res.produce) begin
			code_q  <= res.code;
			debug_q <= res.debug;
		end
	end

	assign out_valid     = out_valid_q;
	assign command_code  = code_q;
	assign debug_enabled = debug_q;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && res.produce |=> out_valid_q)
		else $error("decoded command did not reach the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && valid_s1 && res.produce |-> in_stall && !s1_go)
		else $error("pending output word would be overwritten");

endmodule
`default_nettype wire

FILE: rtl/core/ukcd_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukcd_matcher
// Prefix match of the kept letters against the keyword table in priority order.
// ----------------------------------------------------------------------------
module ukcd_matcher #(
	parameter int CountWidth = 5
) (
	input  ukcd_pkg::letters_t          letters,
	input  logic [CountWidth-1:0]       letter_count,
	input  ukcd_pkg::cfg_t              cfg,
	output ukcd_pkg::cmd_code_t         code
);
	import ukcd_pkg::*;

	logic [KeywordCount-1:0] hit;

	function automatic logic group_on(input group_t group, input cfg_t c);
		logic on;
		unique case (group)
			GroupAlways:    on = 1'b1;
			GroupSplit:     on = c.split_central;
			GroupTransport: on = c.transport_group;
			GroupHogp:      on = c.hogp_group;
		endcase
		return on;
	endfunction

	always_comb begin
		logic same;
		for (int k = 0; k < KeywordCount; k++) begin
			same = 1'b1;
			for (int i = 0; i < KeptLetters; i++) begin
				if (i < int'(Keywords[k].len)) begin
					if (letters[i] != kw_letter(Keywords[k], i)) begin
						same = 1'b0;
					end
				end
			end
			hit[k] = same && group_on(Keywords[k].group, cfg) &&
				(letter_count >= CountWidth'(Keywords[k].len));
		end
	end

	always_comb begin
		code = CodeUnknown;
		for (int k = KeywordCount - 1; k >= 0; k--) begin
			if (hit[k]) begin
				code = Keywords[k].code;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ukcd_line_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukcd_line_state
// Command state, letter count, kept letters and debug flag, updated per byte.
// ----------------------------------------------------------------------------
module ukcd_line_state #(
	parameter int BUFFER_LENGTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [7:0]             rx_byte,
	input  ukcd_pkg::cfg_t         cfg,
	output ukcd_pkg::line_result_t result
);
	import ukcd_pkg::*;

	localparam int CountWidth = $clog2(BUFFER_LENGTH);
	localparam logic [CountWidth-1:0] MaxCount = CountWidth'(BUFFER_LENGTH - 1);
	localparam logic [CountWidth-1:0] KeptCount = CountWidth'(KeptLetters);

	logic                  active_q;
	logic [CountWidth-1:0] count_q;
	logic                  debug_q;
	letters_t              letters_q;

	logic      is_bang;
	logic      is_eol;
	logic      is_letter;
	logic      is_erase;
	logic      produce;
	cmd_code_t code;
	logic      debug_next;

	assign is_bang   = (rx_byte == CharBang);
	assign is_eol    = (rx_byte == CharCr) || (rx_byte == CharLf);
	assign is_letter = (rx_byte >= CharA) && (rx_byte <= CharZ);
	assign is_erase  = (rx_byte == CharDel) || (rx_byte == CharBs);
	assign produce   = is_eol && active_q && (count_q != '0);

	ukcd_matcher #(
		.CountWidth(CountWidth)
	) u_matcher (
		.letters     (letters_q),
		.letter_count(count_q),
		.cfg         (cfg),
		.code        (code)
	);

	always_comb begin
		priority if (code == CodeDebug) begin
			debug_next = 1'b1;
		end else if (code == CodeNoDebug) begin
			debug_next = 1'b0;
		end else begin
			debug_next = debug_q;
		end
	end

	assign result.produce = produce;
	assign result.code    = code;
	assign result.debug   = debug_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			debug_q  <= 1'b0;
		end else if (go) begin
			priority if (is_bang) begin
				active_q <= 1'b1;
				count_q  <= '0;
			end else if (is_eol) begin
				active_q <= 1'b0;
				count_q  <= '0;
				if (produce) begin
					debug_q <= debug_next;
				end
			end else if (active_q) begin
				if (is_letter && (count_q < MaxCount)) begin
					count_q <= count_q + 1'b1;
				end else if (is_erase && (count_q != '0)) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && active_q && !is_bang && !is_eol && is_letter &&
			(count_q < MaxCount) && (count_q < KeptCount)) begin
			letters_q[count_q[3:0]] <= rx_byte[4:0];
		end
	end

	a_bang_starts: assert property (@(posedge clk) disable iff (!arst_n)
		go && is_bang |=> active_q && (count_q == '0))
		else $error("start byte did not open an empty command");

	a_debug_only_on_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(debug_q) |-> $past(go && produce))
		else $error("debug flag changed without a completed command");

endmodule
`default_nettype wire
